// ----- rtl/core/rpc_pkg.sv -----
// Package for the rising product coefficient block: widths, payload
// structs, sequencer codes and the request/response structs of the
// shared multiply-add unit. No dependencies.
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int unsigned COEF_W = 64;
  localparam int unsigned HALF_W = COEF_W / 2;
  localparam int unsigned TC_W   = 7;
  localparam int unsigned PIDX_W = 6;

  // Input item
  typedef struct packed {
    logic [COEF_W-1:0] start_offset;
    logic [TC_W-1:0]   term_count;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic [PIDX_W-1:0] power_index;
    logic              last_flag;
    logic              count_error;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_MUL,
    S_RA,
    S_RD,
    S_ERA,
    S_EMIT
  } state_e;

  // Which coefficient the running multiply-add produces
  typedef enum logic [2:0] {
    PH_INIT0,
    PH_INIT1,
    PH_TOP,
    PH_INNER,
    PH_ZERO
  } phase_e;

  // Multiply-add request: result = mul_a * mul_b + addend (mod 2^64)
  typedef struct packed {
    logic              start;
    logic [COEF_W-1:0] mul_a;
    logic [COEF_W-1:0] mul_b;
    logic [COEF_W-1:0] addend;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [COEF_W-1:0] result;
  } mul_rsp_t;

endpackage

// ----- rtl/core/rpc_stream_if.sv -----
// Valid/ready stream interface carrying one payload struct per item.
// Payload type is given at instantiation (see rpc_pkg).
`timescale 1ns / 1ps

interface rpc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/rpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rpc_mul_add.sv -----
// Shared 64-bit multiply-add unit built on one 32x32 multiplier, three
// partial products in turn. Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_mul_add (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpc_pkg::mul_req_t req_i,
  output rpc_pkg::mul_rsp_t rsp_o
);
  import rpc_pkg::*;

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [COEF_W-1:0] a_q, b_q, acc_q;
  logic [1:0]        step_q;
  logic              busy_q, done_q;
  logic [HALF_W-1:0] mx, my;
  logic [COEF_W-1:0] prod, addend;

  // Pick the partial product for this step; cross terms only need low halves
  always_comb begin
    mx     = (step_q == STEP_HL) ? a_q[COEF_W-1:HALF_W] : a_q[HALF_W-1:0];
    my     = (step_q == STEP_LH) ? b_q[COEF_W-1:HALF_W] : b_q[HALF_W-1:0];
    prod   = COEF_W'(mx) * COEF_W'(my);
    addend = (step_q == STEP_LL) ? prod : {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LL;
    end else begin
      done_q <= busy_q && (step_q == STEP_HL);
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_LL;
      end else if (busy_q) begin
        if (step_q == STEP_HL) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.mul_a;
      b_q   <= req_i.mul_b;
      acc_q <= req_i.addend;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

// ----- rtl/core/rpc_ctrl.sv -----
// Sequencer: expands the rising product factor by factor through the
// shared multiply-add unit and the coefficient RAM, then streams the
// coefficients out. Depends on rpc_pkg and rpc_stream_if.
`timescale 1ns / 1ps

module rpc_ctrl #(
  parameter int unsigned MAX_TERMS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rpc_stream_if.sink                   in_i,
  rpc_stream_if.source                 out_o,
  output rpc_pkg::mul_req_t            mul_req_o,
  input  rpc_pkg::mul_rsp_t            mul_rsp_i,
  output logic                         ram_we_o,
  output logic [$clog2(MAX_TERMS)-1:0] ram_waddr_o,
  output logic [rpc_pkg::COEF_W-1:0]   ram_wdata_o,
  output logic [$clog2(MAX_TERMS)-1:0] ram_raddr_o,
  input  logic [rpc_pkg::COEF_W-1:0]   ram_rdata_i
);
  import rpc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  state_e            state_q, state_d;
  phase_e            ph_q, ph_d;
  logic [COEF_W-1:0] k_q, k_d, d_q, d_d, cur_q, cur_d;
  logic [CW-1:0]     l_q, l_d, i_q, i_d, j_q, j_d, e_q, e_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [CW-1:0]     l_in;
  logic              in_fire, short_cnt;
  logic              mul_done;

  // Accept a request only while idle
  assign in_i.ready = (state_q == S_IDLE);

  assign in_fire   = in_i.valid && in_i.ready;
  assign short_cnt = in_i.payload.term_count < TC_W'(2);
  assign l_in      = (int'(in_i.payload.term_count) > int'(MAX_TERMS)) ?
                     CW'(MAX_TERMS) : CW'(in_i.payload.term_count);
  assign mul_done  = (state_q == S_MUL) && mul_rsp_i.done;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = short_cnt ? S_ERR : S_MUL;
      end
      S_ERR: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      S_MUL: begin
        if (mul_rsp_i.done) begin
          unique case (ph_q)
            PH_INIT0: state_d = S_MUL;
            PH_INIT1: state_d = (l_q == CW'(2)) ? S_ERA : S_RA;
            PH_TOP:   state_d = S_RA;
            PH_INNER: state_d = (j_q == CW'(1)) ? S_MUL : S_RA;
            PH_ZERO:  state_d = (i_q + CW'(1) == l_q) ? S_ERA : S_RA;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_RA:   state_d = S_RD;
      S_RD:   state_d = S_MUL;
      S_ERA:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_o.ready) state_d = (e_q + CW'(1) == l_q) ? S_IDLE : S_ERA;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath updates and port outputs
  always_comb begin
    ph_d   = ph_q;
    k_d    = k_q;
    d_d    = d_q;
    cur_d  = cur_q;
    l_d    = l_q;
    i_d    = i_q;
    j_d    = j_q;
    e_d    = e_q;
    addr_d = addr_q;

    mul_req_o = '0;

    out_o.valid   = (state_q == S_ERR) || (state_q == S_EMIT);
    out_o.payload = '0;

    ram_we_o    = mul_done;
    ram_wdata_o = mul_rsp_i.result;
    ram_raddr_o = addr_q;
    ram_waddr_o = '0;

    // Write target of the running multiply-add
    case (ph_q)
      PH_INIT1: ram_waddr_o = AW'(1);
      PH_TOP:   ram_waddr_o = i_q[AW-1:0];
      PH_INNER: ram_waddr_o = j_q[AW-1:0];
      default:  ram_waddr_o = '0;
    endcase

    // Result item fields
    if (state_q == S_ERR) begin
      out_o.payload.last_flag   = 1'b1;
      out_o.payload.count_error = 1'b1;
    end else begin
      out_o.payload.coefficient = ram_rdata_i;
      out_o.payload.power_index = PIDX_W'(e_q);
      out_o.payload.last_flag   = (e_q + CW'(1) == l_q);
    end

    case (state_q)
      // Take a request and form k*(k+1)
      S_IDLE: begin
        if (in_fire && !short_cnt) begin
          k_d              = in_i.payload.start_offset;
          l_d              = l_in;
          ph_d             = PH_INIT0;
          mul_req_o.start  = 1'b1;
          mul_req_o.mul_a  = in_i.payload.start_offset;
          mul_req_o.mul_b  = in_i.payload.start_offset + COEF_W'(1);
        end
      end
      // Launch the multiply-add on the fetched coefficient
      S_RD: begin
        mul_req_o.start = 1'b1;
        cur_d           = ram_rdata_i;
        if (ph_q == PH_TOP) begin
          mul_req_o.mul_a  = ram_rdata_i;
          mul_req_o.mul_b  = COEF_W'(1);
          mul_req_o.addend = d_q;
        end else begin
          mul_req_o.mul_a  = cur_q;
          mul_req_o.mul_b  = d_q;
          mul_req_o.addend = ram_rdata_i;
        end
      end
      // Advance through the rounds as each coefficient lands
      S_MUL: begin
        if (mul_rsp_i.done) begin
          case (ph_q)
            PH_INIT0: begin
              ph_d             = PH_INIT1;
              mul_req_o.start  = 1'b1;
              mul_req_o.mul_a  = k_q;
              mul_req_o.mul_b  = COEF_W'(2);
              mul_req_o.addend = COEF_W'(1);
            end
            PH_INIT1: begin
              if (l_q == CW'(2)) begin
                e_d    = '0;
                addr_d = '0;
              end else begin
                i_d    = CW'(2);
                d_d    = k_q + COEF_W'(2);
                addr_d = AW'(1);
                ph_d   = PH_TOP;
              end
            end
            PH_TOP: begin
              j_d    = i_q - CW'(1);
              addr_d = AW'(i_q - CW'(2));
              ph_d   = PH_INNER;
            end
            PH_INNER: begin
              if (j_q == CW'(1)) begin
                ph_d            = PH_ZERO;
                mul_req_o.start = 1'b1;
                mul_req_o.mul_a = cur_q;
                mul_req_o.mul_b = d_q;
              end else begin
                j_d    = j_q - CW'(1);
                addr_d = AW'(j_q - CW'(2));
              end
            end
            PH_ZERO: begin
              i_d = i_q + CW'(1);
              if (i_q + CW'(1) == l_q) begin
                e_d    = '0;
                addr_d = '0;
              end else begin
                d_d    = d_q + COEF_W'(1);
                addr_d = i_q[AW-1:0];
                ph_d   = PH_TOP;
              end
            end
            default: ph_d = PH_INIT0;
          endcase
        end
      end
      // Step the emit pointer on each taken item
      S_EMIT: begin
        if (out_o.ready) begin
          e_d    = e_q + CW'(1);
          addr_d = AW'(e_q + CW'(1));
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_INIT0;
      l_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      e_q     <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      l_q     <= l_d;
      i_q     <= i_d;
      j_q     <= j_d;
      e_q     <= e_d;
      addr_q  <= addr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    d_q   <= d_d;
    cur_q <= cur_d;
  end

endmodule

// ----- rtl/core/rising_product_coeffs_single_word.sv -----
// Channel  Dir  Payload (rpc_pkg)                                   Handshake
// in_i     in   in_item_t: start_offset, term_count                 valid/ready
// out_o    out  out_item_t: coefficient, power_index, last_flag,    valid/ready
//                           count_error
//
// One request at a time; in_i.ready is high only while the block is idle.
// Each multiply-add runs on the shared 32x32 unit; the top and inner steps read the
// coefficient RAM (S_RA, S_RD) ahead of it. A request of l terms (l clipped to
// MAX_TERMS) is expanded first, then each coefficient is read (S_ERA) and emitted
// (S_EMIT). A count below two yields one error item. Reset is asynchronous and
// clears the sequencer and the multiply-add control only; the coefficient RAM
// needs no clearing. Output stalls simply hold the current item.
`timescale 1ns / 1ps

module rising_product_coeffs_single_word #(
  parameter int unsigned MAX_TERMS = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  rpc_stream_if.sink   in_i,
  rpc_stream_if.source out_o
);
  import rpc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_TERMS);

  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [COEF_W-1:0] ram_wdata, ram_rdata;

  // Sequencer
  rpc_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Shared multiply-add unit
  rpc_mul_add u_mul_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Coefficient store
  rpc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TERMS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- tb/rising_product_coeffs_single_word_tb.sv -----
// Testbench for rising_product_coeffs_single_word: drives start offset / term
// count requests and checks every emitted coefficient against a local expansion.
// Depends on rpc_pkg, rpc_stream_if and the block itself.
`timescale 1ns / 1ps

module rising_product_coeffs_single_word_tb;
  import rpc_pkg::*;

  localparam int unsigned MAX_TERMS    = 64;
  localparam int unsigned RANDOM_REQS  = 274;
  localparam int unsigned IDLE_PERCENT = 11;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rpc_stream_if #(.payload_t(in_item_t))  req_if ();
  rpc_stream_if #(.payload_t(out_item_t)) rsp_if ();

  rising_product_coeffs_single_word #(
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  always #2 clk_i = ~clk_i;

  in_item_t    pending_requests[$];
  out_item_t   expected_coeffs[$];
  int unsigned requests_sent  = 0;
  int unsigned coeffs_seen    = 0;
  int unsigned count_errors   = 0;
  int unsigned saturated_reqs = 0;
  int unsigned fail_count     = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 64'd50_000_000;

  // No idling on either side while this window of requests goes through
  function automatic bit in_quiet_window();
    return (requests_sent >= 120) && (requests_sent < 170);
  endfunction

  function automatic bit roll_idle();
    return !in_quiet_window() && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Expand (x+k)(x+k+1)...(x+k+l-1) and queue the l low coefficients
  function automatic void expand_rising_product(in_item_t req);
    logic [COEF_W-1:0] coef [MAX_TERMS];
    logic [COEF_W-1:0] k;
    logic [COEF_W-1:0] d;
    int unsigned       terms;
    out_item_t         item;
    k     = req.start_offset;
    terms = req.term_count;
    if (terms < 2) begin
      item             = '0;
      item.last_flag   = 1'b1;
      item.count_error = 1'b1;
      expected_coeffs.push_back(item);
      return;
    end
    if (terms > MAX_TERMS) terms = MAX_TERMS;
    coef[0] = k * (k + 64'd1);
    coef[1] = 64'd2 * k + 64'd1;
    for (int i = 2; i < terms; i++) begin
      d       = k + 64'(i);
      coef[i] = coef[i-1] + d;
      for (int j = i - 1; j >= 1; j--) coef[j] = coef[j] * d + coef[j-1];
      coef[0] = coef[0] * d;
    end
    for (int j = 0; j < terms; j++) begin
      item.coefficient = coef[j];
      item.power_index = PIDX_W'(j);
      item.last_flag   = (j + 1 == terms);
      item.count_error = 1'b0;
      expected_coeffs.push_back(item);
    end
  endfunction

  function automatic logic [COEF_W-1:0] pick_offset();
    case ($urandom_range(3))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(1000));
      2:       return '1 - 64'($urandom_range(1000));
      default: return 64'd1 << $urandom_range(63);
    endcase
  endfunction

  function automatic logic [TC_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return TC_W'($urandom_range(1));
    if (roll < 12) return TC_W'($urandom_range(127, 60));
    return TC_W'($urandom_range(16, 2));
  endfunction

  function automatic void queue_request(logic [COEF_W-1:0] k, logic [TC_W-1:0] cnt);
    in_item_t req;
    req.start_offset = k;
    req.term_count   = cnt;
    pending_requests.push_back(req);
  endfunction

  // Rough cycle cost of one request, used for the run limit
  function automatic longint unsigned request_cost(in_item_t req);
    longint unsigned terms;
    terms = req.term_count;
    if (terms < 2) return 10;
    if (terms > MAX_TERMS) terms = MAX_TERMS;
    return 3 * terms * terms + 3 * terms + 40;
  endfunction

  // Driver: advance to the next request once the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        expand_rising_product(req_if.payload);
        requests_sent++;
        if (req_if.payload.term_count < 2) count_errors++;
        if (req_if.payload.term_count > MAX_TERMS) saturated_reqs++;
      end
      if (pending_requests.size() > 0 && !roll_idle()) begin
        req_if.payload <= pending_requests.pop_front();
        req_if.valid   <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken coefficient with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        coeffs_seen++;
        if (expected_coeffs.size() == 0) begin
          $display("%0t unexpected item: expected none, got %p", $time, rsp_if.payload);
          fail_count++;
        end else begin
          want = expected_coeffs.pop_front();
          if (rsp_if.payload.coefficient !== want.coefficient) begin
            $display("%0t coefficient mismatch: expected %h, got %h", $time,
                     want.coefficient, rsp_if.payload.coefficient);
            fail_count++;
          end
          if (rsp_if.payload.power_index !== want.power_index) begin
            $display("%0t power_index mismatch: expected %0d, got %0d", $time,
                     want.power_index, rsp_if.payload.power_index);
            fail_count++;
          end
          if (rsp_if.payload.last_flag !== want.last_flag) begin
            $display("%0t last_flag mismatch: expected %b, got %b", $time,
                     want.last_flag, rsp_if.payload.last_flag);
            fail_count++;
          end
          if (rsp_if.payload.count_error !== want.count_error) begin
            $display("%0t count_error mismatch: expected %b, got %b", $time,
                     want.count_error, rsp_if.payload.count_error);
            fail_count++;
          end
        end
      end
      rsp_if.ready <= !roll_idle();
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("FAIL rising_product_coeffs_single_word");
      $finish;
    end
  end

  initial begin
    longint unsigned budget;

    // Directed: error counts, the smallest and largest counts, offset extremes
    queue_request(pick_offset(), 7'd0);
    queue_request('1, 7'd1);
    queue_request('0, 7'd2);
    queue_request('1, 7'd2);
    queue_request('0, 7'd3);
    queue_request('1 - 64'd1, 7'd3);
    queue_request(64'h8000_0000_0000_0000, 7'd4);
    queue_request(64'h0000_0000_FFFF_FFFF, 7'd5);
    queue_request(64'd1, 7'd10);
    queue_request('0, 7'd63);
    queue_request(64'd1, 7'd64);
    queue_request(pick_offset(), 7'd65);
    queue_request('1, 7'd127);
    queue_request(64'h5555_5555_5555_5555, 7'd1);
    queue_request(64'hAAAA_AAAA_AAAA_AAAA, 7'd7);
    queue_request(64'hAAAA_AAAA_AAAA_AAAA, 7'd0);

    // Random: mostly small counts, a few error and saturating ones
    repeat (RANDOM_REQS) queue_request(pick_offset(), pick_count());

    // Allow for output stalls and input gaps several times over
    budget = 0;
    foreach (pending_requests[i]) budget += request_cost(pending_requests[i]);
    cycle_limit = 8 * budget + 100_000;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last request to be taken and its coefficients to drain
    while (pending_requests.size() > 0 || req_if.valid) @(posedge clk_i);
    while (expected_coeffs.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_coeffs.size() > 0) begin
      $display("%0t %0d coefficients never arrived", $time, expected_coeffs.size());
      fail_count++;
    end
    $display("Sent %0d requests (%0d with a count below two, %0d above capacity)",
             requests_sent, count_errors, saturated_reqs);
    $display("Checked %0d result items in %0d cycles, %0d mismatches",
             coeffs_seen, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("PASS rising_product_coeffs_single_word");
    end else begin
      $display("FAIL rising_product_coeffs_single_word");
    end
    $finish;
  end

endmodule
